>>> design/date_validate_day_distance_top_assert.svh
// Assertion macros used by the top-level design file.
// Each macro checks a property on the rising edge of clk, idle during reset.
`ifndef DATE_VALIDATE_DAY_DISTANCE_TOP_ASSERT_SVH
`define DATE_VALIDATE_DAY_DISTANCE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DVDD_ASSERT_SAME(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DVDD_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> design/dvdd_pkg.sv
package dvdd_pkg;

	// Field widths.
	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int SECOND_W = 6;
	localparam int STATUS_W = 2;
	localparam int DIST_W   = 22;

	// Day number from 0000-01-01; 23 bits cover every 14-bit year.
	localparam int DN_W    = 23;
	localparam int DOY_W   = 9;
	localparam int QUART_W = YEAR_W - 1;

	// Division by 100 and by 400 through one reciprocal: 41944 is
	// ceil(2^22 / 100) and also ceil(2^24 / 400), exact for 15-bit dividends.
	localparam int RECIP_W = 16;
	localparam logic [RECIP_W-1:0] RECIP_100 = 16'd41944;
	localparam int SH_100  = 22;
	localparam int SH_400  = 24;
	localparam int Q100_W  = 8;
	localparam int Q400_W  = 6;

	localparam logic [YEAR_W-1:0] ROUND_100 = 14'd99;
	localparam logic [YEAR_W-1:0] ROUND_400 = 14'd399;
	localparam logic [YEAR_W-1:0] ROUND_4   = 14'd3;
	localparam logic [DN_W-1:0]   DAYS_PER_YEAR = 23'd365;

	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [DAY_W-1:0]   FEB_LEAP_LEN = 5'd29;

	localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
	localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;
	localparam logic [SECOND_W-1:0] SECOND_MAX = 6'd59;

	// Bits of the status code.
	localparam int STATUS_DATE_BIT = 0;
	localparam int STATUS_TIME_BIT = 1;

	// Month length in a common year; zero marks a month that does not exist.
	localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
		5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
		5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
	};

	// Days in a common year before the first of each month.
	localparam logic [DOY_W-1:0] DAYS_BEFORE [16] = '{
		9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
		9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0, 9'd0, 9'd0
	};

	// Per-stage load enables of the pipeline.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} dvdd_adv_t;

endpackage

>>> design/dvdd_date_pipe.sv
module dvdd_date_pipe import dvdd_pkg::*; #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  logic               clk,
	input  dvdd_adv_t          adv,
	input  logic [YEAR_W-1:0]  year,
	input  logic [MONTH_W-1:0] month,
	input  logic [DAY_W-1:0]   day,
	output logic               ok_s3,
	output logic [DN_W-1:0]    dn_s3
);

	localparam int PW = YEAR_W + 1 + RECIP_W;

	// Stage 1: century quotients by reciprocal multiplication.
	logic [YEAR_W:0]     y99, y399;
	logic [PW-1:0]       p99, p399, p0;
	logic                in_range;

	assign y99  = {1'b0, year} + {1'b0, ROUND_100};
	assign y399 = {1'b0, year} + {1'b0, ROUND_400};
	assign p99  = PW'(y99) * PW'(RECIP_100);
	assign p399 = PW'(y399) * PW'(RECIP_100);
	assign p0   = PW'(year) * PW'(RECIP_100);
	assign in_range = 32'(year) <= 32'(MAX_YEAR);

	logic [YEAR_W-1:0]  y_s1;
	logic [MONTH_W-1:0] m_s1;
	logic [DAY_W-1:0]   d_s1;
	logic               inr_s1;
	logic [Q100_W-1:0]  q100u_s1, q100_s1;
	logic [Q400_W-1:0]  q400u_s1;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			y_s1     <= year;
			m_s1     <= month;
			d_s1     <= day;
			inr_s1   <= in_range;
			q100u_s1 <= p99[SH_100 +: Q100_W];
			q100_s1  <= p0[SH_100 +: Q100_W];
			q400u_s1 <= p399[SH_400 +: Q400_W];
		end
	end

	// Stage 2: leap rule, date check, day of year and year terms.
	logic               y_div4, y_div100, y_div400, leap;
	logic [DAY_W-1:0]   mlen;
	logic               ok;
	logic [DOY_W-1:0]   doy;
	logic [YEAR_W:0]    y3;
	logic [QUART_W-1:0] yq;
	logic [DN_W-1:0]    ylow;

	assign y_div4   = y_s1[1:0] == 2'b00;
	// y is a multiple of 100 exactly when rounding up adds nothing.
	assign y_div100 = q100u_s1 == q100_s1;
	assign y_div400 = y_div100 && (q100_s1[1:0] == 2'b00);
	assign leap     = (y_div4 && !y_div100) || y_div400;
	assign mlen     = (m_s1 == MONTH_FEB && leap) ? FEB_LEAP_LEN : MONTH_LEN[m_s1];
	assign ok       = inr_s1 && (d_s1 != '0) && (d_s1 <= mlen);
	assign doy      = DAYS_BEFORE[m_s1] + DOY_W'(leap && (m_s1 > MONTH_FEB))
	                + DOY_W'(d_s1) - DOY_W'(1);
	assign y3       = {1'b0, y_s1} + {1'b0, ROUND_4};
	assign yq       = y3[YEAR_W:2] - QUART_W'(q100u_s1) + QUART_W'(q400u_s1);
	assign ylow     = DN_W'(y_s1) * DAYS_PER_YEAR;

	logic               ok_s2;
	logic [DOY_W-1:0]   doy_s2;
	logic [QUART_W-1:0] yq_s2;
	logic [DN_W-1:0]    ylow_s2;

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			ok_s2   <= ok;
			doy_s2  <= doy;
			yq_s2   <= yq;
			ylow_s2 <= ylow;
		end
	end

	// Stage 3: day number.
	always_ff @(posedge clk) begin
		if (adv.s3) begin
			ok_s3 <= ok_s2;
			dn_s3 <= ylow_s2 + DN_W'(yq_s2) + DN_W'(doy_s2);
		end
	end

endmodule

>>> design/date_validate_day_distance_top.sv
// Gregorian date check and day distance.
// Input channel: in_valid / in_ready carry one pair of dates, the first with a
// time of day. Output channel: out_valid / out_ready carry status_a, date_b_ok
// and day_distance, one result for each input transfer, in order.
// status_a bit 0 flags a bad first date, bit 1 a bad time of day. day_distance
// is the absolute day count between the dates, zero if either date is bad.
// The block is a four-stage pipeline: quotients by 100 and 400 through
// reciprocal multipliers, the date check and year terms, the day numbers, and
// the difference into the output register. A result moves through the stage 1,
// 2, 3 and 4 registers after its input transfer; one transfer per cycle is
// sustained while out_ready stays high; the multiplier stage sets the clock.
// Each stage has its own valid bit and loads while it is empty or its
// successor loads, so a stalled receiver holds the output register and the
// pipeline fills behind it before in_ready drops; nothing is lost or repeated.
// Reset clears the valid bits only; the pipeline is empty and ready at once.
module date_validate_day_distance_top import dvdd_pkg::*; #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [YEAR_W-1:0]   year_a,
	input  logic [MONTH_W-1:0]  month_a,
	input  logic [DAY_W-1:0]    day_a,
	input  logic [HOUR_W-1:0]   hour_a,
	input  logic [MINUTE_W-1:0] minute_a,
	input  logic [SECOND_W-1:0] second_a,
	input  logic [YEAR_W-1:0]   year_b,
	input  logic [MONTH_W-1:0]  month_b,
	input  logic [DAY_W-1:0]    day_b,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status_a,
	output logic                date_b_ok,
	output logic [DIST_W-1:0]   day_distance
);

	`include "date_validate_day_distance_top_assert.svh"

	// Pipeline flow control.
	logic      v_s1, v_s2, v_s3, v_s4;
	logic      rdy1, rdy2, rdy3, rdy4;
	dvdd_adv_t adv;

	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;
	assign adv      = '{s1: rdy1, s2: rdy2, s3: rdy3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// Date pipes for both dates.
	logic            ok_a_s3, ok_b_s3;
	logic [DN_W-1:0] dn_a_s3, dn_b_s3;

	dvdd_date_pipe #(.MAX_YEAR(MAX_YEAR)) u_pipe_a (
		.clk   (clk),
		.adv   (adv),
		.year  (year_a),
		.month (month_a),
		.day   (day_a),
		.ok_s3 (ok_a_s3),
		.dn_s3 (dn_a_s3)
	);

	dvdd_date_pipe #(.MAX_YEAR(MAX_YEAR)) u_pipe_b (
		.clk   (clk),
		.adv   (adv),
		.year  (year_b),
		.month (month_b),
		.day   (day_b),
		.ok_s3 (ok_b_s3),
		.dn_s3 (dn_b_s3)
	);

	// Time-of-day check, carried alongside the date pipes.
	logic t_ok_s1, t_ok_s2, t_ok_s3;

	always_ff @(posedge clk) begin
		if (rdy1) t_ok_s1 <= (hour_a <= HOUR_MAX) && (minute_a <= MINUTE_MAX)
		                     && (second_a <= SECOND_MAX);
		if (rdy2) t_ok_s2 <= t_ok_s1;
		if (rdy3) t_ok_s3 <= t_ok_s2;
	end

	// Stage 4: status and absolute distance into the output register.
	logic [DN_W-1:0]     diff;
	logic [STATUS_W-1:0] status;

	assign diff = (dn_a_s3 > dn_b_s3) ? (dn_a_s3 - dn_b_s3) : (dn_b_s3 - dn_a_s3);

	always_comb begin
		status                  = '0;
		status[STATUS_DATE_BIT] = !ok_a_s3;
		status[STATUS_TIME_BIT] = !t_ok_s3;
	end

	logic [STATUS_W-1:0] status_s4;
	logic                b_ok_s4;
	logic [DIST_W-1:0]   dist_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			status_s4 <= status;
			b_ok_s4   <= ok_b_s3;
			dist_s4   <= (ok_a_s3 && ok_b_s3) ? diff[DIST_W-1:0] : '0;
		end
	end

	assign out_valid    = v_s4;
	assign status_a     = status_s4;
	assign date_b_ok    = b_ok_s4;
	assign day_distance = dist_s4;

	// Checks on the pipeline and the result.
	`DVDD_ASSERT_SAME(a_dist_zero_on_bad, out_valid && (status_a[STATUS_DATE_BIT] || !date_b_ok), day_distance == '0, "distance not zero for an invalid date")
	`DVDD_ASSERT_NEXT(a_in_fills_s1, in_valid && in_ready, v_s1, "input transfer did not reach stage 1")
	`DVDD_ASSERT_NEXT(a_s3_held, v_s3 && !rdy3, v_s3 && $stable(dn_a_s3) && $stable(dn_b_s3), "stalled stage 3 lost its item")

endmodule

>>> test/date_validate_day_distance_checker.sv
`timescale 1ns / 100ps

// Watches both channels, predicts each result from the accepted input
// transfer and compares it against the result transfers in order.
module date_validate_day_distance_checker import dvdd_pkg::*; #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [YEAR_W-1:0]   year_a,
	input  logic [MONTH_W-1:0]  month_a,
	input  logic [DAY_W-1:0]    day_a,
	input  logic [HOUR_W-1:0]   hour_a,
	input  logic [MINUTE_W-1:0] minute_a,
	input  logic [SECOND_W-1:0] second_a,
	input  logic [YEAR_W-1:0]   year_b,
	input  logic [MONTH_W-1:0]  month_b,
	input  logic [DAY_W-1:0]    day_b,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [STATUS_W-1:0] status_a,
	input  logic                date_b_ok,
	input  logic [DIST_W-1:0]   day_distance,
	output int                  mismatches,
	output int                  outstanding
);

	typedef struct packed {
		logic [STATUS_W-1:0] status_a;
		logic                date_b_ok;
		logic [DIST_W-1:0]   day_distance;
	} date_result_t;

	// Results still owed by the block, oldest first.
	date_result_t distance_q[$];

	function automatic bit leap_year(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	// Length of a month; zero for a month number that does not exist.
	function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
		if (m == MONTH_FEB)
			return leap_year(y) ? 29 : 28;
		case (m)
			4, 6, 9, 11: return 30;
			1, 3, 5, 7, 8, 10, 12: return 31;
			default: return 0;
		endcase
	endfunction

	function automatic bit calendar_date_ok(input int unsigned y, input int unsigned m,
			input int unsigned d);
		return (y <= MAX_YEAR) && (d >= 1) && (d <= month_length(y, m));
	endfunction

	// Days elapsed since the first of January of year zero.
	function automatic int unsigned days_since_epoch(input int unsigned y,
			input int unsigned m, input int unsigned d);
		int unsigned n;
		n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
		for (int unsigned k = 1; k < m; k++)
			n += month_length(y, k);
		return n + d - 1;
	endfunction

	function automatic date_result_t predict_distance();
		date_result_t r;
		bit a_ok;
		bit b_ok;
		bit t_ok;
		int unsigned na;
		int unsigned nb;
		a_ok = calendar_date_ok(year_a, month_a, day_a);
		b_ok = calendar_date_ok(year_b, month_b, day_b);
		t_ok = (hour_a <= 23) && (minute_a <= 59) && (second_a <= 59);
		r = '0;
		r.status_a[STATUS_DATE_BIT] = !a_ok;
		r.status_a[STATUS_TIME_BIT] = !t_ok;
		r.date_b_ok = b_ok;
		// The distance is only defined when both dates are valid.
		if (a_ok && b_ok) begin
			na = days_since_epoch(year_a, month_a, day_a);
			nb = days_since_epoch(year_b, month_b, day_b);
			r.day_distance = DIST_W'(na > nb ? na - nb : nb - na);
		end
		return r;
	endfunction

	// Result transfers are retired before input transfers are queued, since a
	// result can never belong to an input accepted at the same edge.
	always @(posedge clk) begin : monitor
		date_result_t want;
		int errs;
		errs = 0;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (distance_q.size() == 0) begin
					$display("%0t: result transfer with nothing expected: status_a %0d date_b_ok %0d day_distance %0d",
						$time, status_a, date_b_ok, day_distance);
					errs++;
				end else begin
					want = distance_q.pop_front();
					if (status_a !== want.status_a) begin
						$display("%0t: status_a expected %0d actual %0d",
							$time, want.status_a, status_a);
						errs++;
					end
					if (date_b_ok !== want.date_b_ok) begin
						$display("%0t: date_b_ok expected %0d actual %0d",
							$time, want.date_b_ok, date_b_ok);
						errs++;
					end
					if (day_distance !== want.day_distance) begin
						$display("%0t: day_distance expected %0d actual %0d",
							$time, want.day_distance, day_distance);
						errs++;
					end
				end
			end
			if (in_valid && in_ready)
				distance_q.push_back(predict_distance());
		end
		mismatches <= mismatches + errs;
		outstanding <= distance_q.size();
	end

endmodule

>>> test/date_validate_day_distance_top_test.sv
`timescale 1ns / 100ps

module date_validate_day_distance_top_test;
	import dvdd_pkg::*;

	typedef struct packed {
		logic [YEAR_W-1:0]   year_a;
		logic [MONTH_W-1:0]  month_a;
		logic [DAY_W-1:0]    day_a;
		logic [HOUR_W-1:0]   hour_a;
		logic [MINUTE_W-1:0] minute_a;
		logic [SECOND_W-1:0] second_a;
		logic [YEAR_W-1:0]   year_b;
		logic [MONTH_W-1:0]  month_b;
		logic [DAY_W-1:0]    day_b;
	} date_pair_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [YEAR_W-1:0]   year_a;
	logic [MONTH_W-1:0]  month_a;
	logic [DAY_W-1:0]    day_a;
	logic [HOUR_W-1:0]   hour_a;
	logic [MINUTE_W-1:0] minute_a;
	logic [SECOND_W-1:0] second_a;
	logic [YEAR_W-1:0]   year_b;
	logic [MONTH_W-1:0]  month_b;
	logic [DAY_W-1:0]    day_b;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status_a;
	logic                date_b_ok;
	logic [DIST_W-1:0]   day_distance;
	int                  mismatches;
	int                  outstanding;

	date_pair_t offer;
	int  send_idle_pct;
	int  stall_pct = 0;
	logic hold_off = 1'b0;
	logic pressure_go = 1'b0;

	assign {year_a, month_a, day_a, hour_a, minute_a, second_a, year_b, month_b, day_b} = offer;

	date_validate_day_distance_top dut (.*);

	date_validate_day_distance_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#400000;
		$display("date_validate_day_distance_top: mismatch");
		$finish;
	end

	// Receiver: random stalls, plus a long hold-off while the pressure stretch runs.
	always @(posedge clk) begin
		out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
	end

	// Long receiver hold-off so that the pipeline fills and in_ready drops.
	initial begin
		wait (pressure_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (80) @(posedge clk);
		hold_off <= 1'b0;
	end

	function automatic date_pair_t make_pair(input int unsigned ya, input int unsigned ma,
			input int unsigned da, input int unsigned ha, input int unsigned mi,
			input int unsigned se, input int unsigned yb, input int unsigned mb,
			input int unsigned db);
		date_pair_t p;
		p.year_a = YEAR_W'(ya);
		p.month_a = MONTH_W'(ma);
		p.day_a = DAY_W'(da);
		p.hour_a = HOUR_W'(ha);
		p.minute_a = MINUTE_W'(mi);
		p.second_a = SECOND_W'(se);
		p.year_b = YEAR_W'(yb);
		p.month_b = MONTH_W'(mb);
		p.day_b = DAY_W'(db);
		return p;
	endfunction

	// Mostly plausible dates with random content; some years on century
	// boundaries, some out of range, and a share of raw noise.
	function automatic logic [YEAR_W-1:0] random_year();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 5)
			return YEAR_W'($urandom_range(10000, 16383));
		if (pick < 15)
			case ($urandom_range(5))
				0: return YEAR_W'(0);
				1: return YEAR_W'(100);
				2: return YEAR_W'(400);
				3: return YEAR_W'(1900);
				4: return YEAR_W'(2000);
				default: return YEAR_W'(9999);
			endcase
		return YEAR_W'($urandom_range(0, 9999));
	endfunction

	function automatic logic [DAY_W-1:0] random_day();
		if ($urandom_range(3) == 0)
			return DAY_W'($urandom_range(29, 31));
		return DAY_W'($urandom_range(1, 28));
	endfunction

	function automatic date_pair_t random_pair();
		date_pair_t p;
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		p = raw[$bits(date_pair_t)-1:0];
		if ($urandom_range(99) < 85) begin
			p.year_a = random_year();
			p.month_a = MONTH_W'($urandom_range(1, 12));
			p.day_a = random_day();
			p.year_b = random_year();
			p.month_b = MONTH_W'($urandom_range(1, 12));
			p.day_b = random_day();
			if ($urandom_range(99) < 85) begin
				p.hour_a = HOUR_W'($urandom_range(0, 23));
				p.minute_a = MINUTE_W'($urandom_range(0, 59));
				p.second_a = SECOND_W'($urandom_range(0, 59));
			end
		end
		return p;
	endfunction

	// Offers one pair, with random idle cycles ahead of it, and waits for the transfer.
	task automatic send_pair(input date_pair_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		offer <= p;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		offer <= '0;
		send_idle_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes and the calendar corner cases.
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_pair(make_pair(0, 1, 1, 0, 0, 0, 9999, 12, 31));
		send_pair(make_pair(9999, 12, 31, 23, 59, 59, 0, 1, 1));
		send_pair(make_pair(0, 2, 29, 12, 30, 30, 0, 3, 1));
		send_pair(make_pair(1900, 2, 29, 1, 1, 1, 1900, 3, 1));
		send_pair(make_pair(2000, 2, 29, 2, 2, 2, 2024, 2, 29));
		send_pair(make_pair(2023, 2, 29, 3, 3, 3, 2023, 2, 28));
		send_pair(make_pair(2023, 4, 31, 4, 4, 4, 2023, 4, 30));
		send_pair(make_pair(2023, 13, 1, 5, 5, 5, 2023, 1, 1));
		send_pair(make_pair(2023, 14, 1, 6, 6, 6, 2023, 1, 1));
		send_pair(make_pair(2023, 15, 31, 7, 7, 7, 2023, 1, 1));
		send_pair(make_pair(2023, 6, 15, 8, 8, 8, 2023, 0, 15));
		send_pair(make_pair(2023, 6, 15, 9, 9, 9, 2023, 15, 15));
		send_pair(make_pair(10000, 1, 1, 10, 10, 10, 2000, 1, 1));
		send_pair(make_pair(2000, 1, 1, 11, 11, 11, 16383, 1, 1));
		send_pair(make_pair(1999, 12, 31, 24, 0, 0, 2000, 1, 1));
		send_pair(make_pair(1999, 12, 31, 31, 63, 63, 2000, 1, 1));
		send_pair(make_pair(1999, 1, 1, 0, 60, 0, 2001, 1, 1));
		send_pair(make_pair(1999, 1, 1, 0, 0, 60, 2001, 1, 1));
		send_pair(make_pair(2020, 0, 10, 24, 0, 0, 2020, 5, 5));
		send_pair(make_pair(2020, 12, 31, 13, 14, 15, 2020, 1, 1));
		send_pair(make_pair(2020, 7, 4, 0, 0, 0, 2020, 7, 0));
		send_pair(make_pair(4321, 9, 9, 0, 0, 0, 4321, 9, 9));
		send_pair(make_pair(16383, 15, 31, 31, 63, 63, 16383, 15, 31));

		// Random phases: no idling with a long receiver hold-off, then sender
		// gaps, receiver stalls, and both.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					stall_pct <= 0;
					pressure_go <= 1'b1;
				end
				1: begin
					send_idle_pct = 46;
					stall_pct <= 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct <= 46;
				end
				default: begin
					send_idle_pct = 36;
					stall_pct <= 36;
				end
			endcase
			repeat (260)
				send_pair(random_pair());
		end
		in_valid <= 1'b0;

		// Drain the pipeline, then keep watching for stray results before the verdict.
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("date_validate_day_distance_top: match");
		else
			$display("date_validate_day_distance_top: mismatch");
		$finish;
	end

endmodule
